/* sv/kce_pkg.sv */
// ============================================================================
// kce_pkg
// Shared types, constants and the base encoder of the k-mer code expander.
// ============================================================================
package kce_pkg;

  // Default configuration and field widths.
  localparam int KMER_LEN_DEF  = 12;
  localparam int MAX_WILD_DEF  = 2;
  localparam int CODE_W        = 24;
  localparam int POS_W         = 32;
  localparam int CHAR_W        = 8;

  // ASCII codes of the recognized base letters.
  localparam logic [CHAR_W-1:0] CHR_UC_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHR_LC_C = 8'h63;
  localparam logic [CHAR_W-1:0] CHR_UC_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHR_LC_G = 8'h67;
  localparam logic [CHAR_W-1:0] CHR_UC_T = 8'h54;
  localparam logic [CHAR_W-1:0] CHR_LC_T = 8'h74;
  localparam logic [CHAR_W-1:0] CHR_UC_N = 8'h4E;
  localparam logic [CHAR_W-1:0] CHR_LC_N = 8'h6E;

  // 2-bit base codes.
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } kce_state_e;

  // One encoded base: wildcard flag plus its 2-bit code.
  typedef struct packed {
    logic       wild;
    logic [1:0] code;
  } kce_base_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // input transaction this cycle
    logic load;    // load the first variant of a new window
    logic step;    // advance to the next variant
  } kce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_ok; // the offered base completes a window that emits
    logic last;    // the variant on the output is the final one
  } kce_stat_t;

  // Map an ASCII character to its base code; unknown letters count as A.
  function automatic kce_base_t encode_base(input logic [CHAR_W-1:0] ch);
    kce_base_t b;
    b = '0;
    unique case (ch) inside
      CHR_UC_C, CHR_LC_C: b.code = BASE_C;
      CHR_UC_G, CHR_LC_G: b.code = BASE_G;
      CHR_UC_T, CHR_LC_T: b.code = BASE_T;
      CHR_UC_N, CHR_LC_N: b.wild = 1'b1;
      default:            b.code = BASE_A;
    endcase
    return b;
  endfunction

endpackage

/* sv/kce_in_if.sv */
// ============================================================================
// kce_in_if
// Input channel: one base character or a sequence boundary per transaction.
// ============================================================================
interface kce_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [kce_pkg::CHAR_W-1:0]  base_char;

  modport source (output valid, output kind, output base_char, input ready);
  modport sink   (input valid, input kind, input base_char, output ready);
endinterface

/* sv/kce_out_if.sv */
// ============================================================================
// kce_out_if
// Output channel: one k-mer code variant per transaction.
// ============================================================================
interface kce_out_if;
  logic                        valid;
  logic                        ready;
  logic [kce_pkg::CODE_W-1:0]  kmer_code;
  logic [kce_pkg::POS_W-1:0]   start_position;
  logic                        last_variant;

  modport source (output valid, output kmer_code, output start_position,
                  output last_variant, input ready);
  modport sink   (input valid, input kmer_code, input start_position,
                  input last_variant, output ready);
endinterface

/* sv/kce_ctrl.sv */
// ============================================================================
// kce_ctrl
// Controller: accepts input transactions and paces the variant output.
// ============================================================================
module kce_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  input  kce_pkg::kce_stat_t  stat_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output kce_pkg::kce_cmd_t   cmd_o
);

  kce_pkg::kce_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kce_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a window that emits holds us in EMIT until its last variant goes.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kce_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.emit_ok) begin
          state_d = kce_pkg::ST_EMIT;
        end
      end
      kce_pkg::ST_EMIT: begin
        if (out_ready_i && stat_i.last) begin
          state_d = (in_valid_i && stat_i.emit_ok) ? kce_pkg::ST_EMIT
                                                    : kce_pkg::ST_IDLE;
        end
      end
      default: state_d = kce_pkg::ST_IDLE;
    endcase
  end

  // Outputs: the next item may enter as the final variant is taken.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      kce_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      kce_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i && stat_i.last;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.accept = in_valid_i && in_ready_o;
    cmd_o.load   = cmd_o.accept && stat_i.emit_ok;
    cmd_o.step   = out_valid_o && out_ready_i && !stat_i.last;
  end

endmodule

/* sv/kce_datapath.sv */
// ============================================================================
// kce_datapath
// Base window shift line, wildcard bookkeeping and variant code generation.
// ============================================================================
module kce_datapath #(
  parameter int KMER_LEN      = kce_pkg::KMER_LEN_DEF,
  parameter int MAX_WILDCARDS = kce_pkg::MAX_WILD_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kce_pkg::kce_cmd_t           cmd_i,
  output kce_pkg::kce_stat_t          stat_o,
  input  logic                        in_kind_i,
  input  logic [kce_pkg::CHAR_W-1:0]  in_char_i,
  output logic [kce_pkg::CODE_W-1:0]  kmer_code_o,
  output logic [kce_pkg::POS_W-1:0]   start_position_o,
  output logic                        last_variant_o
);

  localparam int BW    = 2 * KMER_LEN;
  localparam int PW    = (KMER_LEN > 1) ? $clog2(KMER_LEN) : 1;
  localparam int FW    = $clog2(KMER_LEN + 1);
  localparam int WW    = (FW > 2) ? FW : 2;
  localparam int MW    = MAX_WILDCARDS;
  localparam int LW    = (MW > 0) ? MW : 1;
  localparam int VIW   = (MW > 0) ? 2 * MW : 1;
  localparam int CodeW = kce_pkg::CODE_W;
  localparam int PosW  = kce_pkg::POS_W;

  localparam logic [FW-1:0]   FILL_FULL = FW'(KMER_LEN);
  localparam logic [WW-1:0]   WILD_MAX  = WW'(MW);
  localparam logic [PW-1:0]   POS_LAST  = PW'(KMER_LEN - 1);
  localparam logic [PosW-1:0] POS_BACK  = PosW'(KMER_LEN - 1);

  // Window state: base codes (wildcards as zero) and wildcard flags, oldest lowest.
  logic [BW-1:0]       base_q;
  logic [KMER_LEN-1:0] wild_q;
  logic [FW-1:0]       fill_q;
  logic [WW-1:0]       wcnt_q;
  logic [PosW-1:0]     cnt_q;
  // Positions of the most recent wildcards, oldest at index 0.
  logic [PW-1:0]       lpos_q [LW];

  // Output registers and variant index.
  logic [VIW-1:0]      vi_q;
  logic [CodeW-1:0]    code_q;
  logic [PosW-1:0]     start_q;
  logic                last_q;

  kce_pkg::kce_base_t  enc;
  logic                full;
  logic                leave;
  logic                rm;
  logic [BW-1:0]       base_nx;
  logic [KMER_LEN-1:0] wild_nx;
  logic [FW-1:0]       fill_nx;
  logic [WW-1:0]       wcnt_nx;
  logic [WW-1:0]       lcnt_min;
  logic [WW-1:0]       lcnt_a;
  logic [PW-1:0]       list_a [LW];
  logic [PW-1:0]       list_b [LW];
  logic [VIW-1:0]      vi_nx;
  logic [BW-1:0]       var_code;
  logic                var_last;

  // Window update for an incoming base: shift in at the top, drop the oldest.
  always_comb begin
    enc      = kce_pkg::encode_base(in_char_i);
    full     = (fill_q == FILL_FULL);
    leave    = full && wild_q[0];
    base_nx  = (base_q >> 2) | (BW'(enc.wild ? 2'b00 : enc.code) << (BW - 2));
    wild_nx  = (wild_q >> 1) | (KMER_LEN'(enc.wild) << (KMER_LEN - 1));
    fill_nx  = full ? FILL_FULL : fill_q + FW'(1);
    wcnt_nx  = wcnt_q - WW'(leave) + WW'(enc.wild);
    stat_o.emit_ok = !in_kind_i && (fill_nx == FILL_FULL) && (wcnt_nx <= WILD_MAX);
    stat_o.last    = last_q;
  end

  // Wildcard list: every position moves down by one; the departing
  // wildcard is removed only when the list holds every wildcard.
  always_comb begin
    lcnt_min = (wcnt_q > WILD_MAX) ? WILD_MAX : wcnt_q;
    rm       = leave && (wcnt_q <= WILD_MAX);
    lcnt_a   = rm ? lcnt_min - WW'(1) : lcnt_min;
    for (int i = 0; i < LW; i++) begin
      list_a[i] = lpos_q[i] - PW'(1);
    end
    for (int i = 0; i < MW - 1; i++) begin
      if (rm) begin
        list_a[i] = lpos_q[i + 1] - PW'(1);
      end
    end
    list_b = list_a;
    if (enc.wild) begin
      if (lcnt_a == WILD_MAX) begin
        for (int i = 0; i < MW - 1; i++) begin
          list_b[i] = list_a[i + 1];
        end
        if (MW > 0) begin
          list_b[LW - 1] = POS_LAST;
        end
      end else begin
        for (int i = 0; i < MW; i++) begin
          if (lcnt_a == WW'(i)) begin
            list_b[i] = POS_LAST;
          end
        end
      end
    end
  end

  // Next variant: digit m of the index fills the m-th wildcard position.
  always_comb begin
    vi_nx    = vi_q + VIW'(1);
    var_code = base_q;
    var_last = 1'b1;
    for (int m = 0; m < MW; m++) begin
      if (wcnt_q > WW'(m)) begin
        var_code = var_code | (BW'(vi_nx[2*m +: 2]) << {lpos_q[m], 1'b0});
        if (vi_nx[2*m +: 2] != 2'b11) begin
          var_last = 1'b0;
        end
      end
    end
  end

  // Control state: fill level, wildcard count and global base counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wcnt_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.accept) begin
      if (in_kind_i) begin
        fill_q <= '0;
        wcnt_q <= '0;
      end else begin
        fill_q <= fill_nx;
        wcnt_q <= wcnt_nx;
        cnt_q  <= cnt_q + PosW'(1);
      end
    end
  end

  // Window contents and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !in_kind_i) begin
      base_q <= base_nx;
      wild_q <= wild_nx;
      lpos_q <= list_b;
    end
    if (cmd_i.load) begin
      vi_q    <= '0;
      code_q  <= CodeW'(base_nx);
      start_q <= cnt_q - POS_BACK;
      last_q  <= (wcnt_nx == '0);
    end else if (cmd_i.step) begin
      vi_q    <= vi_nx;
      code_q  <= CodeW'(var_code);
      last_q  <= var_last;
    end
  end

  assign kmer_code_o      = code_q;
  assign start_position_o = start_q;
  assign last_variant_o   = last_q;

endmodule

/* sv/kmer_code_wildcard_expand.sv */
// ============================================================================
// kmer_code_wildcard_expand
// Streams genome bases into a k-mer window and emits 2-bit k-mer codes,
// expanding N wildcards into all of their variants.
// ============================================================================
//
//  Channel  Dir  Payload                                      Accepted when
//  in_i     in   kind, base_char                              valid && ready
//  out_o    out  kmer_code, start_position, last_variant      valid && ready
//
//  A base or boundary that completes no emitting window is taken and produces no output.
//  A window with n wildcards (n <= MAX_WILDCARDS) emits 4^n variants, one per
//  output transaction; the variant counter steps through them.
//  The next item enters in the same cycle as the final variant is taken.
//  Output stalls hold the current variant and block the input.
//  Reset clears the fill level, wildcard count and base counter; no clearing pass.
//
module kmer_code_wildcard_expand #(
  parameter int KMER_LEN      = kce_pkg::KMER_LEN_DEF,
  parameter int MAX_WILDCARDS = kce_pkg::MAX_WILD_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kce_in_if.sink    in_i,
  kce_out_if.source out_o
);

  kce_pkg::kce_cmd_t  cmd;
  kce_pkg::kce_stat_t stat;

  // Sequencer for transactions on both channels.
  kce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // Window and variant datapath.
  kce_datapath #(
    .KMER_LEN      (KMER_LEN),
    .MAX_WILDCARDS (MAX_WILDCARDS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_kind_i        (in_i.kind),
    .in_char_i        (in_i.base_char),
    .kmer_code_o      (out_o.kmer_code),
    .start_position_o (out_o.start_position),
    .last_variant_o   (out_o.last_variant)
  );

endmodule

/* sv/kce_checker.sv */
// ============================================================================
// kce_checker
// Port-level checks of the k-mer code expander, bound to the top level.
// ============================================================================
module kce_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_kind_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [kce_pkg::CODE_W-1:0]  out_code_i,
  input logic [kce_pkg::POS_W-1:0]   out_start_i,
  input logic                        out_last_i
);

  // No input transaction while a variant other than a taken last one waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !(out_ready_i && out_last_i) |-> !in_ready_i)
    else $error("input accepted while variants are still pending");

  // A boundary transaction never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i |=> !out_valid_i)
    else $error("result after a boundary transaction");

  // All variants of one window share the start position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && $stable(out_start_i))
    else $error("variant sequence broken or start position changed");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_code_i))
    else $error("stalled result changed");

endmodule

bind kmer_code_wildcard_expand kce_checker u_kce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_code_i  (out_o.kmer_code),
  .out_start_i (out_o.start_position),
  .out_last_i  (out_o.last_variant)
);
